### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the frustum cull blocks.
// Both macros sample on i_clk and name the check with the given label.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle check, disabled while i_rst_n is low.
`define FAC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// Next-cycle check: ante in one cycle implies cons in the following one.
`define FAC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);
`else
`define FAC_ASSERT(lbl, prop, msg)
`define FAC_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

### sv/fac_pkg.sv
// ----------------------------------------------------------------------------
// fac_pkg
// Types, register map and constants of the frustum cull and classify block.
// ----------------------------------------------------------------------------
package fac_pkg;

    // Plane units and plane registers.
    localparam int FAC_PLANE_COUNT = 6;
    localparam int FAC_PLANE_REGS  = 6;
    localparam int FAC_QUEUE_DEPTH = 4;

    // Configuration port geometry: 64-bit registers at 8-byte spacing.
    localparam int FAC_DATA_W = 64;
    localparam int FAC_ADDR_W = 6;
    localparam int FAC_IDX_W  = 3;

    // Register indexes.
    localparam logic [FAC_IDX_W-1:0] REG_PLANE_LEFT    = 3'd0;
    localparam logic [FAC_IDX_W-1:0] REG_PLANE_RIGHT   = 3'd1;
    localparam logic [FAC_IDX_W-1:0] REG_PLANE_BOTTOM  = 3'd2;
    localparam logic [FAC_IDX_W-1:0] REG_PLANE_TOP     = 3'd3;
    localparam logic [FAC_IDX_W-1:0] REG_PLANE_NEAR    = 3'd4;
    localparam logic [FAC_IDX_W-1:0] REG_PLANE_FAR     = 3'd5;
    localparam logic [FAC_IDX_W-1:0] REG_OPACITY_LIMIT = 3'd6;

    // Opacity limit after reset: 0.999 in Q1.15, rounded up.
    localparam logic [15:0] FAC_OPACITY_RESET = 16'd32736;

    // Plane test accumulator: three 32-bit products plus d scaled by 2^14.
    localparam int FAC_ACC_W   = 34;
    localparam int FAC_D_SHIFT = 14;

    typedef logic [FAC_DATA_W-1:0] t_plane;
    typedef logic [31:0]           t_cnt;
    typedef logic [47:0]           t_tri_sum;

    // One draw item.
    typedef struct packed {
        logic              frame_start;
        logic signed [15:0] min_x;
        logic signed [15:0] min_y;
        logic signed [15:0] min_z;
        logic signed [15:0] max_x;
        logic signed [15:0] max_y;
        logic signed [15:0] max_z;
        logic              bounds_valid;
        logic              has_material;
        logic [15:0]       opacity;
        logic              cast_shadows;
        logic [23:0]       triangles;
    } t_in_item;

    // One result with the frame counters after this item.
    typedef struct packed {
        logic     is_visible;
        logic     is_transparent;
        logic     is_shadow_caster;
        t_cnt     submitted_count;
        t_cnt     culled_count;
        t_cnt     visible_count;
        t_cnt     invalid_count;
        t_tri_sum triangle_total;
        t_cnt     shadow_count;
        t_cnt     opaque_count;
        t_cnt     transparent_count;
    } t_out_item;

    // Classified item passed from the front part to the counting back part.
    typedef struct packed {
        logic        frame_start;
        logic        visible;
        logic        bounds_valid;
        logic        transparent;
        logic        shadow;
        logic [23:0] triangles;
    } t_cls_item;

endpackage

### sv/frustum_aabb_cull_classify.sv
// ----------------------------------------------------------------------------
// Path: an item passes two plane-test stages, the queue and the counter stage
// to o_valid and waits there while the output side stalls. Throughput: one
// item per cycle while the output is taken, set by the pipelined plane units
// and the counter update; a 4-entry queue absorbs short output stalls.
// Reset (i_rst_n low, synchronous): counters and planes cleared, opacity
// limit set to 32736, pipeline and queue emptied.
// ----------------------------------------------------------------------------
// ----------------------------------------------------------------------------
// frustum_aabb_cull_classify
// Culls draw item boxes against clip planes, classifies them and keeps
// saturating per-frame counters.
// ----------------------------------------------------------------------------
module frustum_aabb_cull_classify import fac_pkg::*; #(
    parameter int PLANE_COUNT = FAC_PLANE_COUNT,
    parameter int QUEUE_DEPTH = FAC_QUEUE_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  t_in_item              i_in,
    output logic                  o_valid,
    input  logic                  i_ready,
    output t_out_item             o_out,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [FAC_ADDR_W-1:0] paddr,
    input  logic [FAC_DATA_W-1:0] pwdata,
    output logic [FAC_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [PLANE_COUNT-1:0][FAC_DATA_W-1:0] w_planes;
    logic [15:0]                            w_opacity_limit;
    logic                                   w_f_valid;
    logic                                   w_f_ready;
    t_cls_item                              w_f_item;
    logic                                   w_q_valid;
    logic                                   w_q_ready;
    t_cls_item                              w_q_item;

    // Configuration registers.
    fac_regs #(
        .PLANE_COUNT(PLANE_COUNT)
    ) u_regs (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .o_planes        (w_planes),
        .o_opacity_limit (w_opacity_limit)
    );

    // Plane test and classification.
    fac_front #(
        .PLANE_COUNT(PLANE_COUNT)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_in            (i_in),
        .i_planes        (w_planes),
        .i_opacity_limit (w_opacity_limit),
        .o_valid         (w_f_valid),
        .i_ready         (w_f_ready),
        .o_item          (w_f_item)
    );

    // Decoupling queue.
    fac_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_f_valid),
        .o_ready (w_f_ready),
        .i_item  (w_f_item),
        .o_valid (w_q_valid),
        .i_ready (w_q_ready),
        .o_item  (w_q_item)
    );

    // Frame counters and result register.
    fac_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .o_q_ready (w_q_ready),
        .i_item    (w_q_item),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_out     (o_out)
    );

endmodule

### sv/fac_regs.sv
// ----------------------------------------------------------------------------
// fac_regs
// APB register file: six clip planes and the opacity limit.
// ----------------------------------------------------------------------------
module fac_regs import fac_pkg::*; #(
    parameter int PLANE_COUNT = FAC_PLANE_COUNT
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [FAC_ADDR_W-1:0]          paddr,
    input  logic [FAC_DATA_W-1:0]          pwdata,
    output logic [FAC_DATA_W-1:0]          prdata,
    output logic                           pready,
    output logic [PLANE_COUNT-1:0][FAC_DATA_W-1:0] o_planes,
    output logic [15:0]                    o_opacity_limit
);

    t_plane                r_plane [FAC_PLANE_REGS];
    logic [15:0]           r_opacity;
    logic [FAC_IDX_W-1:0]  w_idx;
    logic                  w_wr;

    // Registers sit at 8-byte spacing.
    assign w_idx  = paddr[FAC_ADDR_W-1:FAC_ADDR_W-FAC_IDX_W];
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;

    // Register writes; an index past the list is dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < FAC_PLANE_REGS; i++) begin
                r_plane[i] <= '0;
            end
            r_opacity <= FAC_OPACITY_RESET;
        end else if (w_wr) begin
            case (w_idx)
                REG_OPACITY_LIMIT: begin
                    r_opacity <= pwdata[15:0];
                end
                default: begin
                    if (w_idx < FAC_IDX_W'(FAC_PLANE_REGS)) begin
                        r_plane[w_idx] <= pwdata;
                    end
                end
            endcase
        end
    end

    // Register reads.
    always_comb begin
        case (w_idx)
            REG_OPACITY_LIMIT: begin
                prdata = {{(FAC_DATA_W-16){1'b0}}, r_opacity};
            end
            default: begin
                if (w_idx < FAC_IDX_W'(FAC_PLANE_REGS)) begin
                    prdata = r_plane[w_idx];
                end else begin
                    prdata = '0;
                end
            end
        endcase
    end

    // Plane units past the configured planes see an all-zero plane.
    for (genvar p = 0; p < PLANE_COUNT; p++) begin : g_plane_out
        if (p < FAC_PLANE_REGS) begin : g_real
            assign o_planes[p] = r_plane[p];
        end else begin : g_zero
            assign o_planes[p] = '0;
        end
    end

    assign o_opacity_limit = r_opacity;

endmodule

### sv/fac_front.sv
// ----------------------------------------------------------------------------
// fac_front
// Two-stage plane test and classification of draw items.
// ----------------------------------------------------------------------------
module fac_front import fac_pkg::*; #(
    parameter int PLANE_COUNT = FAC_PLANE_COUNT
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  t_in_item                               i_in,
    input  logic [PLANE_COUNT-1:0][FAC_DATA_W-1:0] i_planes,
    input  logic [15:0]                            i_opacity_limit,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output t_cls_item                              o_item
);

    logic                    r_s1_valid;
    t_cls_item               r_s1_info;
    logic signed [31:0]      r_prod [PLANE_COUNT][3];
    logic                    r_s2_valid;
    t_cls_item               r_s2_item;
    t_cls_item               n_s2_item;
    logic                    w_s1_ready;
    logic                    w_s2_ready;
    logic                    w_s1_load;
    logic [PLANE_COUNT-1:0]  w_outside;

    // Each stage moves on when the one after it has room.
    assign w_s2_ready = !r_s2_valid || i_ready;
    assign w_s1_ready = !r_s1_valid || w_s2_ready;
    assign w_s1_load  = i_valid && w_s1_ready;
    assign o_ready    = w_s1_ready;

    // One plane unit per plane: corner pick and products, then the signed sum.
    for (genvar p = 0; p < PLANE_COUNT; p++) begin : g_plane
        logic signed [15:0]          w_a;
        logic signed [15:0]          w_b;
        logic signed [15:0]          w_c;
        logic signed [15:0]          w_d;
        logic signed [15:0]          w_vx;
        logic signed [15:0]          w_vy;
        logic signed [15:0]          w_vz;
        logic signed [FAC_ACC_W-1:0] w_acc;

        assign w_a = i_planes[p][15:0];
        assign w_b = i_planes[p][31:16];
        assign w_c = i_planes[p][47:32];
        assign w_d = i_planes[p][63:48];

        // The corner farthest along the normal: max where the coefficient is >= 0.
        assign w_vx = w_a[15] ? i_in.min_x : i_in.max_x;
        assign w_vy = w_b[15] ? i_in.min_y : i_in.max_y;
        assign w_vz = w_c[15] ? i_in.min_z : i_in.max_z;

        always_ff @(posedge i_clk) begin
            if (w_s1_load) begin
                r_prod[p][0] <= w_a * w_vx;
                r_prod[p][1] <= w_b * w_vy;
                r_prod[p][2] <= w_c * w_vz;
            end
        end

        // Exact sum with 18 fraction bits; negative means the box is outside.
        assign w_acc = FAC_ACC_W'(r_prod[p][0]) + FAC_ACC_W'(r_prod[p][1])
                     + FAC_ACC_W'(r_prod[p][2])
                     + (FAC_ACC_W'(w_d) <<< FAC_D_SHIFT);
        assign w_outside[p] = w_acc[FAC_ACC_W-1];
    end

    // Stage one: side information and the transparency compare.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_s1_ready) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_load) begin
            r_s1_info.frame_start  <= i_in.frame_start;
            r_s1_info.visible      <= 1'b1;
            r_s1_info.bounds_valid <= i_in.bounds_valid;
            r_s1_info.transparent  <= i_in.has_material && (i_in.opacity < i_opacity_limit);
            r_s1_info.shadow       <= i_in.cast_shadows;
            r_s1_info.triangles    <= i_in.triangles;
        end
    end

    // Stage two: combine the plane results; an invalid box always passes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (w_s2_ready) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_comb begin
        n_s2_item         = r_s1_info;
        n_s2_item.visible = !r_s1_info.bounds_valid || !(|w_outside);
    end

    always_ff @(posedge i_clk) begin
        if (w_s2_ready && r_s1_valid) begin
            r_s2_item <= n_s2_item;
        end
    end

    assign o_valid = r_s2_valid;
    assign o_item  = r_s2_item;

endmodule

### sv/fac_queue.sv
// ----------------------------------------------------------------------------
// fac_queue
// Short register queue that decouples classification from counting.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fac_queue import fac_pkg::*; #(
    parameter int DEPTH = FAC_QUEUE_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_cls_item i_item,
    output logic      o_valid,
    input  logic      i_ready,
    output t_cls_item o_item
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cls_item        r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_push;
    logic             w_pop;

    assign o_ready = (r_count != CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;
    assign o_item  = r_mem[r_rd_ptr];

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    // The fill count stays within the depth and agrees with the pointers.
    `FAC_ASSERT(fac_q_count_bound, (r_count <= CNT_W'(DEPTH)), "queue fill count over depth")
    `FAC_ASSERT(fac_q_empty_ptrs, ((r_count == '0) |-> (r_wr_ptr == r_rd_ptr)), "empty queue with unequal pointers")
    `FAC_ASSERT_NXT(fac_q_push_fill, (w_push && !w_pop), (r_count != '0), "push left queue empty")

endmodule

### sv/fac_back.sv
// ----------------------------------------------------------------------------
// fac_back
// Saturating frame counters and the registered result stage.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fac_back import fac_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_valid,
    output logic      o_q_ready,
    input  t_cls_item i_item,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_out
);

    localparam t_tri_sum TRI_MAX = '1;

    logic      r_valid;
    t_out_item r_out;
    t_out_item n_out;
    logic      w_take;

    function automatic t_cnt inc_sat(input t_cnt c);
        return (c == '1) ? c : c + 1'b1;
    endfunction

    // The result register takes a new item whenever it is empty or being taken.
    assign o_q_ready = !r_valid || i_ready;
    assign w_take    = i_q_valid && o_q_ready;

    // Counter update for the item at the head of the queue.
    always_comb begin
        logic [48:0] v_sum;
        n_out = r_out;
        if (i_item.frame_start) begin
            n_out.submitted_count   = '0;
            n_out.culled_count      = '0;
            n_out.visible_count     = '0;
            n_out.invalid_count     = '0;
            n_out.triangle_total    = '0;
            n_out.shadow_count      = '0;
            n_out.opaque_count      = '0;
            n_out.transparent_count = '0;
        end
        n_out.is_visible       = i_item.visible;
        n_out.is_transparent   = i_item.transparent;
        n_out.is_shadow_caster = i_item.shadow;
        n_out.submitted_count  = inc_sat(n_out.submitted_count);
        if (!i_item.bounds_valid) begin
            n_out.invalid_count = inc_sat(n_out.invalid_count);
        end
        if (i_item.shadow) begin
            n_out.shadow_count = inc_sat(n_out.shadow_count);
        end
        v_sum = {1'b0, n_out.triangle_total} + 49'(i_item.triangles);
        if (!i_item.visible) begin
            n_out.culled_count = inc_sat(n_out.culled_count);
        end else begin
            n_out.visible_count  = inc_sat(n_out.visible_count);
            n_out.triangle_total = v_sum[48] ? TRI_MAX : v_sum[47:0];
            if (i_item.transparent) begin
                n_out.transparent_count = inc_sat(n_out.transparent_count);
            end else begin
                n_out.opaque_count = inc_sat(n_out.opaque_count);
            end
        end
    end

    // Result register; its counter fields are the frame state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_out   <= '0;
        end else begin
            if (o_q_ready) begin
                r_valid <= i_q_valid;
            end
            if (w_take) begin
                r_out <= n_out;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_out   = r_out;

    // Every item is submitted, so no class count can pass the submitted count.
    `FAC_ASSERT(fac_vis_le_sub, (r_out.visible_count <= r_out.submitted_count), "visible count above submitted count")
    `FAC_ASSERT(fac_cull_le_sub, (r_out.culled_count <= r_out.submitted_count), "culled count above submitted count")
    `FAC_ASSERT_NXT(fac_take_valid, w_take, r_valid, "taken item not presented")

endmodule

### verif/frustum_cull_checker.sv
// ----------------------------------------------------------------------------
// frustum_cull_checker
// Watches the draw item channel, the result channel and the register bus of
// the frustum cull and classify block. It keeps its own copy of the planes,
// the opacity limit and the frame counters, predicts each result and compares
// it field by field with what the block returns.
// ----------------------------------------------------------------------------
module frustum_cull_checker import fac_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  t_in_item              i_in_item,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  t_out_item             i_out_item,
    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic                  i_pready,
    input  logic [FAC_ADDR_W-1:0] i_paddr,
    input  t_plane                i_pwdata,
    output int                    o_pending,
    output int                    o_error_count
);

    // Byte address bits below the register index.
    localparam int       ADDR_LSB     = $clog2(FAC_DATA_W / 8);
    localparam longint   D_SCALE      = longint'(1) << FAC_D_SHIFT;
    localparam t_cnt     CNT_MAX      = '1;
    localparam t_tri_sum TRI_SUM_MAX  = '1;

    // Shadow copy of the configuration.
    t_plane      cfg_planes [FAC_PLANE_REGS];
    logic [15:0] cfg_opacity_limit;

    // Shadow copy of the frame counters.
    t_cnt     submitted_total;
    t_cnt     culled_total;
    t_cnt     visible_total;
    t_cnt     invalid_total;
    t_tri_sum triangle_sum;
    t_cnt     shadow_total;
    t_cnt     opaque_total;
    t_cnt     transparent_total;

    t_out_item                pending_verdicts [$];
    t_out_item                want;
    logic [FAC_IDX_W-1:0]     reg_idx;
    int                       failure_count = 0;

    function automatic t_cnt sat_inc(input t_cnt c);
        return (c == CNT_MAX) ? c : c + 1'b1;
    endfunction

    function automatic void clear_frame_counters();
        submitted_total   = '0;
        culled_total      = '0;
        visible_total     = '0;
        invalid_total     = '0;
        triangle_sum      = '0;
        shadow_total      = '0;
        opaque_total      = '0;
        transparent_total = '0;
    endfunction

    // The positive corner of the box along the plane normal is tested; the
    // sum is exact in 64 bits with 18 fraction bits.
    function automatic logic behind_plane(input t_plane pl, input t_in_item it);
        logic signed [15:0] coef [3];
        logic signed [15:0] lo [3];
        logic signed [15:0] hi [3];
        logic signed [15:0] offset;
        longint             acc;
        coef[0] = pl[15:0];
        coef[1] = pl[31:16];
        coef[2] = pl[47:32];
        offset  = pl[63:48];
        lo[0] = it.min_x;
        lo[1] = it.min_y;
        lo[2] = it.min_z;
        hi[0] = it.max_x;
        hi[1] = it.max_y;
        hi[2] = it.max_z;
        acc = longint'(offset) * D_SCALE;
        for (int k = 0; k < 3; k++) begin
            acc += longint'(coef[k]) * longint'((coef[k] >= 0) ? hi[k] : lo[k]);
        end
        return acc < 0;
    endfunction

    // Classify one draw item and advance the frame counters.
    function automatic t_out_item classify_draw(input t_in_item it);
        t_out_item r;
        logic      visible;
        logic      transparent;
        if (it.frame_start) begin
            clear_frame_counters();
        end
        // An invalid box is never culled. Planes past the six registers
        // are all zero and cannot cull either.
        visible = 1'b1;
        if (it.bounds_valid) begin
            for (int k = 0; k < FAC_PLANE_REGS; k++) begin
                if (behind_plane(cfg_planes[k], it)) begin
                    visible = 1'b0;
                end
            end
        end
        transparent = it.has_material && (it.opacity < cfg_opacity_limit);

        submitted_total = sat_inc(submitted_total);
        if (!it.bounds_valid) begin
            invalid_total = sat_inc(invalid_total);
        end
        // Shadow casters count whether or not the item is culled.
        if (it.cast_shadows) begin
            shadow_total = sat_inc(shadow_total);
        end
        if (!visible) begin
            culled_total = sat_inc(culled_total);
        end else begin
            visible_total = sat_inc(visible_total);
            if (triangle_sum > TRI_SUM_MAX - t_tri_sum'(it.triangles)) begin
                triangle_sum = TRI_SUM_MAX;
            end else begin
                triangle_sum = triangle_sum + t_tri_sum'(it.triangles);
            end
            if (transparent) begin
                transparent_total = sat_inc(transparent_total);
            end else begin
                opaque_total = sat_inc(opaque_total);
            end
        end

        r.is_visible        = visible;
        r.is_transparent    = transparent;
        r.is_shadow_caster  = it.cast_shadows;
        r.submitted_count   = submitted_total;
        r.culled_count      = culled_total;
        r.visible_count     = visible_total;
        r.invalid_count     = invalid_total;
        r.triangle_total    = triangle_sum;
        r.shadow_count      = shadow_total;
        r.opaque_count      = opaque_total;
        r.transparent_count = transparent_total;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [63:0] exp_val,
                               input logic [63:0] act_val);
        if (act_val !== exp_val) begin
            $error("%s mismatch: expected %0h, actual %0h", name, exp_val, act_val);
            failure_count++;
        end
    endtask

    // Configuration writes first, then the input transfer, then the result
    // transfer, all sampled at the rising edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < FAC_PLANE_REGS; k++) begin
                cfg_planes[k] = '0;
            end
            cfg_opacity_limit = FAC_OPACITY_RESET;
            clear_frame_counters();
            pending_verdicts.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                reg_idx = i_paddr[FAC_ADDR_W-1:ADDR_LSB];
                if (reg_idx <= REG_PLANE_FAR) begin
                    cfg_planes[reg_idx] = i_pwdata;
                end else if (reg_idx == REG_OPACITY_LIMIT) begin
                    cfg_opacity_limit = i_pwdata[15:0];
                end
            end

            if (i_in_valid && i_in_ready) begin
                pending_verdicts.insert(pending_verdicts.size(), classify_draw(i_in_item));
            end

            if (i_out_valid && i_out_ready) begin
                if (pending_verdicts.size() == 0) begin
                    $error("Result transfer with no draw item outstanding");
                    failure_count++;
                end else begin
                    want = pending_verdicts.pop_front();
                    check_field("is_visible", want.is_visible, i_out_item.is_visible);
                    check_field("is_transparent", want.is_transparent,
                                i_out_item.is_transparent);
                    check_field("is_shadow_caster", want.is_shadow_caster,
                                i_out_item.is_shadow_caster);
                    check_field("submitted_count", want.submitted_count,
                                i_out_item.submitted_count);
                    check_field("culled_count", want.culled_count,
                                i_out_item.culled_count);
                    check_field("visible_count", want.visible_count,
                                i_out_item.visible_count);
                    check_field("invalid_count", want.invalid_count,
                                i_out_item.invalid_count);
                    check_field("triangle_total", want.triangle_total,
                                i_out_item.triangle_total);
                    check_field("shadow_count", want.shadow_count,
                                i_out_item.shadow_count);
                    check_field("opaque_count", want.opaque_count,
                                i_out_item.opaque_count);
                    check_field("transparent_count", want.transparent_count,
                                i_out_item.transparent_count);
                end
            end
        end
        o_pending     <= pending_verdicts.size();
        o_error_count <= failure_count;
    end

endmodule

### verif/tb_frustum_aabb_cull_classify.sv
// ----------------------------------------------------------------------------
// tb_frustum_aabb_cull_classify
// Drives draw items into the frustum cull and classify block: a directed set
// of boxes against a cube frustum, then random items over several plane and
// opacity settings, with bursty input and a stalling output side. A separate
// checker predicts and compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_frustum_aabb_cull_classify;
    import fac_pkg::*;

    localparam int CYCLE_LIMIT   = 400_000;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_ITEMS   = 225;
    // Pipeline latency plus margin.
    localparam int SETTLE_CYCLES = 8;
    // An address past the last register, which the block must ignore.
    localparam logic [FAC_IDX_W-1:0] REG_UNMAPPED = 3'd7;
    // 1.0 in Q1.14 and 100 world units in Q12.4.
    localparam int Q14_ONE   = 16384;
    localparam int CUBE_HALF = 1600;

    typedef t_plane t_plane_set [FAC_PLANE_REGS];
    typedef enum {CFG_BOX, CFG_TILTED, CFG_NOISE, CFG_EXTREME, CFG_OPEN} t_frustum_kind;
    typedef enum {RX_OPEN, RX_COIN, RX_HOLD, RX_TOGGLE} t_stall_mode;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_ready;
    t_in_item              i_in;
    logic                  o_valid;
    logic                  i_ready;
    t_out_item             o_out;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [FAC_ADDR_W-1:0] paddr;
    t_plane                pwdata;
    t_plane                prdata;
    logic                  pready;

    int          pending_verdicts;
    int          error_total;
    int          cycle_count = 0;
    t_stall_mode rx_mode = RX_OPEN;
    int          rx_run = 0;

    frustum_aabb_cull_classify dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_in    (i_in),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_out   (o_out),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    frustum_cull_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_valid),
        .i_in_ready    (o_ready),
        .i_in_item     (i_in),
        .i_out_valid   (o_valid),
        .i_out_ready   (i_ready),
        .i_out_item    (o_out),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_pready      (pready),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .o_pending     (pending_verdicts),
        .o_error_count (error_total)
    );

    // Clock with a period of 10.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $error("Run exceeded %0d cycles", CYCLE_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // The result side stalls in runs: always ready, coin flips, held low,
    // or toggling every cycle.
    initial begin
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_run == 0) begin
                rx_mode = t_stall_mode'($urandom_range(0, 3));
                rx_run  = (rx_mode == RX_HOLD) ? $urandom_range(1, 12) : $urandom_range(1, 60);
            end
            rx_run--;
            case (rx_mode)
                RX_OPEN:   i_ready <= 1'b1;
                RX_COIN:   i_ready <= 1'($urandom);
                RX_HOLD:   i_ready <= 1'b0;
                default:   i_ready <= ~i_ready;
            endcase
        end
    end

    function automatic t_plane make_plane(input int a, input int b, input int c, input int d);
        return {16'(d), 16'(c), 16'(b), 16'(a)};
    endfunction

    // Axis-aligned frustum around a center; order is left, right, bottom,
    // top, near, far.
    function automatic t_plane_set cube_planes(input int cx, input int cy, input int cz,
                                               input int hx, input int hy, input int hz);
        t_plane_set pl;
        pl[REG_PLANE_LEFT]   = make_plane(Q14_ONE, 0, 0, hx - cx);
        pl[REG_PLANE_RIGHT]  = make_plane(-Q14_ONE, 0, 0, hx + cx);
        pl[REG_PLANE_BOTTOM] = make_plane(0, Q14_ONE, 0, hy - cy);
        pl[REG_PLANE_TOP]    = make_plane(0, -Q14_ONE, 0, hy + cy);
        pl[REG_PLANE_NEAR]   = make_plane(0, 0, Q14_ONE, hz - cz);
        pl[REG_PLANE_FAR]    = make_plane(0, 0, -Q14_ONE, hz + cz);
        return pl;
    endfunction

    function automatic int extreme_coef();
        case ($urandom_range(0, 4))
            0:       return -32768;
            1:       return 32767;
            2:       return 0;
            3:       return -1;
            default: return 1;
        endcase
    endfunction

    function automatic t_in_item make_item(input logic fs, input int mnx, input int mny,
                                           input int mnz, input int mxx, input int mxy,
                                           input int mxz, input logic valid, input logic mat,
                                           input int opac, input logic shadow, input int tris);
        t_in_item it;
        it.frame_start  = fs;
        it.min_x        = 16'(mnx);
        it.min_y        = 16'(mny);
        it.min_z        = 16'(mnz);
        it.max_x        = 16'(mxx);
        it.max_y        = 16'(mxy);
        it.max_z        = 16'(mxz);
        it.bounds_valid = valid;
        it.has_material = mat;
        it.opacity      = 16'(opac);
        it.cast_shadows = shadow;
        it.triangles    = 24'(tris);
        return it;
    endfunction

    // Mostly well-formed boxes near the frustum; some swapped, some with
    // fully random coordinates.
    function automatic t_in_item rand_item();
        t_in_item it;
        int       lo [3];
        int       hi [3];
        int       shape;
        int       tmp;
        shape = $urandom_range(0, 99);
        for (int k = 0; k < 3; k++) begin
            if (shape < 10) begin
                lo[k] = $urandom;
                hi[k] = $urandom;
            end else begin
                lo[k] = int'($urandom_range(0, 12000)) - 6000;
                hi[k] = lo[k] + int'($urandom_range(0, 2500));
                if (shape < 16) begin
                    tmp   = lo[k];
                    lo[k] = hi[k];
                    hi[k] = tmp;
                end
            end
        end
        it = make_item($urandom_range(0, 39) == 0, lo[0], lo[1], lo[2], hi[0], hi[1], hi[2],
                       $urandom_range(0, 9) != 0, 1'($urandom), 0, 1'($urandom), 0);
        case ($urandom_range(0, 5))
            0:       it.opacity = 16'd32768;
            1:       it.opacity = 16'($urandom_range(0, 32768));
            2:       it.opacity = 16'($urandom_range(32700, 32800));
            3:       it.opacity = 16'($urandom);
            4:       it.opacity = '0;
            default: it.opacity = 16'($urandom_range(0, 65535));
        endcase
        case ($urandom_range(0, 7))
            0:       it.triangles = '1;
            1:       it.triangles = '0;
            2:       it.triangles = 24'($urandom);
            default: it.triangles = 24'($urandom_range(0, 5000));
        endcase
        return it;
    endfunction

    // One transfer on the item channel; returns at the falling edge after it.
    task automatic send_item(input t_in_item it);
        i_valid <= 1'b1;
        i_in    <= it;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Stop sending and wait for every outstanding result.
    task automatic drain();
        i_valid <= 1'b0;
        while (pending_verdicts != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Setup and access cycle; the bus stays selected for a following write.
    task automatic write_reg(input logic [FAC_IDX_W-1:0] idx, input t_plane value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic program_regs(input t_plane_set pl, input logic [15:0] limit);
        for (int k = 0; k < FAC_PLANE_REGS; k++) begin
            write_reg(FAC_IDX_W'(REG_PLANE_LEFT + k), pl[k]);
        end
        write_reg(REG_OPACITY_LIMIT, t_plane'(limit));
        write_reg(REG_UNMAPPED, {$urandom, $urandom});
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic setup_frustum(input t_frustum_kind kind, input logic [15:0] limit);
        t_plane_set pl;
        case (kind)
            CFG_BOX: begin
                pl = cube_planes(int'($urandom_range(0, 4000)) - 2000,
                                 int'($urandom_range(0, 4000)) - 2000,
                                 int'($urandom_range(0, 4000)) - 2000,
                                 $urandom_range(300, 4000), $urandom_range(300, 4000),
                                 $urandom_range(300, 4000));
            end
            CFG_TILTED: begin
                for (int k = 0; k < FAC_PLANE_REGS; k++) begin
                    pl[k] = make_plane(int'($urandom_range(0, 32768)) - 16384,
                                       int'($urandom_range(0, 32768)) - 16384,
                                       int'($urandom_range(0, 32768)) - 16384,
                                       $urandom_range(0, 8000));
                end
            end
            CFG_NOISE: begin
                for (int k = 0; k < FAC_PLANE_REGS; k++) begin
                    pl[k] = {$urandom, $urandom};
                end
            end
            CFG_EXTREME: begin
                for (int k = 0; k < FAC_PLANE_REGS; k++) begin
                    pl[k] = make_plane(extreme_coef(), extreme_coef(), extreme_coef(),
                                       $urandom_range(0, 1) ? 32767 : -32768);
                end
            end
            default: begin
                for (int k = 0; k < FAC_PLANE_REGS; k++) begin
                    pl[k] = '0;
                end
            end
        endcase
        program_regs(pl, limit);
    endtask

    // Directed boxes: field extremes, each plane culling, exact touch,
    // swapped and invalid boxes, and opacity corner values.
    task automatic run_directed();
        int lo [3];
        int hi [3];
        // Reset configuration: all planes zero, nothing is culled.
        send_item(make_item(1'b1, -32768, -32768, -32768, 32767, 32767, 32767,
                            1'b1, 1'b1, 0, 1'b1, 24'hFF_FFFF));
        send_item(make_item(1'b0, 32767, 32767, 32767, -32768, -32768, -32768,
                            1'b1, 1'b0, 16'hFFFF, 1'b0, 0));
        send_item(make_item(1'b0, 0, 0, 0, 0, 0, 0, 1'b0, 1'b1, 32768, 1'b1, 1));
        drain();

        program_regs(cube_planes(0, 0, 0, CUBE_HALF, CUBE_HALF, CUBE_HALF), FAC_OPACITY_RESET);
        // Inside the cube; just below and at the opacity limit.
        send_item(make_item(1'b1, -160, -160, -160, 160, 160, 160,
                            1'b1, 1'b1, 32735, 1'b0, 1000));
        send_item(make_item(1'b0, -160, -160, -160, 160, 160, 160,
                            1'b1, 1'b1, 32736, 1'b1, 24'hFF_FFFF));
        // Box wholly outside each plane in turn; shadow casters among them.
        for (int k = 0; k < FAC_PLANE_REGS; k++) begin
            lo = '{-160, -160, -160};
            hi = '{160, 160, 160};
            if (k % 2 == 0) begin
                lo[k / 2] = -3200;
                hi[k / 2] = -1700;
            end else begin
                lo[k / 2] = 1700;
                hi[k / 2] = 3200;
            end
            send_item(make_item(1'b0, lo[0], lo[1], lo[2], hi[0], hi[1], hi[2],
                                1'b1, 1'(k % 2), 20000, k < 3, 77));
        end
        // Same outside box but marked invalid: it passes and is counted.
        send_item(make_item(1'b0, -3200, 0, 0, -1700, 10, 10, 1'b0, 1'b1, 100, 1'b0, 5));
        // Touching the left plane exactly stays visible; one step past culls.
        send_item(make_item(1'b0, -2000, 0, 0, -CUBE_HALF, 10, 10, 1'b1, 1'b0, 0, 1'b0, 9));
        send_item(make_item(1'b0, -2000, 0, 0, -CUBE_HALF - 1, 10, 10,
                            1'b1, 1'b0, 0, 1'b1, 9));
        // Swapped boxes are tested as given.
        send_item(make_item(1'b0, 1000, 0, 0, -1000, 10, 10, 1'b1, 1'b1, 0, 1'b0, 3));
        send_item(make_item(1'b0, 3000, 0, 0, -3000, 10, 10, 1'b1, 1'b1, 0, 1'b0, 3));
        // New frame on a culled item.
        send_item(make_item(1'b1, 1700, 1700, 1700, 3200, 3200, 3200,
                            1'b1, 1'b0, 0, 1'b1, 11));
        // Opacity above full scale compares unsigned; no material, no transparency.
        send_item(make_item(1'b0, -10, -10, -10, 10, 10, 10, 1'b1, 1'b1, 65535, 1'b0, 2));
        send_item(make_item(1'b0, -10, -10, -10, 10, 10, 10, 1'b1, 1'b0, 0, 1'b0, 24'hFF_FFFF));
        drain();
    endtask

    // Random items in bursts with gaps of random length between them.
    task automatic run_items(input int count);
        int left;
        int burst;
        int gap;
        left = count;
        while (left > 0) begin
            burst = $urandom_range(1, 40);
            if (burst > left) begin
                burst = left;
            end
            repeat (burst) send_item(rand_item());
            left -= burst;
            case ($urandom_range(0, 9))
                0, 1, 2: gap = 0;
                9:       gap = $urandom_range(20, 30);
                default: gap = $urandom_range(1, 8);
            endcase
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
    endtask

    initial begin
        logic [15:0] phase_limit;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_in    = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();

        // Each phase programs the block while idle, then streams random items.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0:       phase_limit = 16'd32768;
                1:       phase_limit = '0;
                2:       phase_limit = FAC_OPACITY_RESET;
                4:       phase_limit = 16'd1;
                default: phase_limit = 16'($urandom_range(0, 32768));
            endcase
            setup_frustum(t_frustum_kind'(p % 5), phase_limit);
            run_items(PHASE_ITEMS);
            drain();
        end

        if (error_total == 0 && pending_verdicts == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
